// ===== src/periodic_nearest_image_assert.svh =====
// assertion macros used by the checker file
`ifndef PERIODIC_NEAREST_IMAGE_ASSERT_SVH
`define PERIODIC_NEAREST_IMAGE_ASSERT_SVH

// same-cycle implication, off while in reset
`define PNI_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("periodic_nearest_image assertion failed");

// implication after a fixed number of cycles, off while in reset
`define PNI_ASSERT_DELAY(label, clk, rst_n, pre, n, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> ##n (post)) \
    else $error("periodic_nearest_image assertion failed");

`endif

// ===== src/pni_pkg.sv =====
package pni_pkg;

  localparam int WORK_W          = 64;
  localparam int WIDE_W          = 128;
  localparam int LIMB_W          = 32;
  localparam int LIMBS           = WIDE_W / LIMB_W;
  localparam int MUL_B_W         = 33;
  localparam int CFG_W           = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int LEN_W           = 31;
  localparam int CODE_W          = 5;
  localparam int DEF_MAX_FOLDS   = 4;
  localparam int DEF_COORD_WIDTH = 32;

  localparam logic [LEN_W-1:0] BOX_LEN_RESET = 31'd1048576;

  localparam logic signed [CODE_W-1:0] SHIFT_X = 5'sd9;
  localparam logic signed [CODE_W-1:0] SHIFT_Y = 5'sd3;
  localparam logic signed [CODE_W-1:0] SHIFT_Z = 5'sd1;

  typedef enum logic [1:0] {
    MODE_VACUUM = 2'd0,
    MODE_RECT   = 2'd1,
    MODE_TRI    = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_MODE = 3'd0,
    REG_BOX_A_X  = 3'd1,
    REG_BOX_B_X  = 3'd2,
    REG_BOX_B_Y  = 3'd3,
    REG_BOX_C_X  = 3'd4,
    REG_BOX_C_Y  = 3'd5,
    REG_BOX_C_Z  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'b00,
    DIR_UP   = 2'b01,
    DIR_DOWN = 2'b10
  } dir_t;

  typedef logic signed [WORK_W-1:0] work_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic  valid;
    logic  ovf;
    dir_t  dir_x;
    dir_t  dir_y;
    dir_t  dir_z;
    work_t vx;
    work_t vy;
    work_t vz;
  } item_t;

  typedef struct packed {
    logic  act;
    logic  strict;
    wide_t len;
    work_t vec_x;
    work_t vec_y;
    work_t vec_z;
  } fold_cfg_t;

  function automatic wide_t widen(input work_t v);
    widen = wide_t'(v);
  endfunction

  function automatic logic signed [CODE_W-1:0] dir_weight(input dir_t d,
      input logic signed [CODE_W-1:0] w);
    logic signed [CODE_W-1:0] r;
    r = '0;
    unique case (d)
      DIR_UP:   r = w;
      DIR_DOWN: r = -w;
      default:  r = '0;
    endcase
    dir_weight = r;
  endfunction

  function automatic int pipe_latency(input int max_folds);
    pipe_latency = 3 * max_folds + 11;
  endfunction

endpackage

// ===== src/pni_dmul.sv =====
module pni_dmul (
  input  logic                                clk,
  input  pni_pkg::wide_t                      a,
  input  logic signed [pni_pkg::MUL_B_W-1:0]  b,
  input  pni_pkg::wide_t                      c,
  input  logic signed [pni_pkg::MUL_B_W-1:0]  d,
  output pni_pkg::wide_t                      p
);

  localparam int PART_W = pni_pkg::LIMB_W + pni_pkg::MUL_B_W + 1;

  logic signed [PART_W-1:0] pa_r   [pni_pkg::LIMBS];
  logic signed [PART_W-1:0] pc_r   [pni_pkg::LIMBS];
  logic signed [PART_W-1:0] pa_nxt [pni_pkg::LIMBS];
  logic signed [PART_W-1:0] pc_nxt [pni_pkg::LIMBS];
  pni_pkg::wide_t           p_r, p_nxt;

  // limb partial products, 33 by 33 each
  always_comb begin
    for (int i = 0; i < pni_pkg::LIMBS; i++) begin
      pa_nxt[i] = PART_W'($signed({1'b0, a[i*pni_pkg::LIMB_W +: pni_pkg::LIMB_W]}))
                * PART_W'(b);
      pc_nxt[i] = PART_W'($signed({1'b0, c[i*pni_pkg::LIMB_W +: pni_pkg::LIMB_W]}))
                * PART_W'(d);
    end
  end

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < pni_pkg::LIMBS; i++) begin
      p_nxt = p_nxt + (pni_pkg::wide_t'(pa_r[i]) <<< (i * pni_pkg::LIMB_W))
                    - (pni_pkg::wide_t'(pc_r[i]) <<< (i * pni_pkg::LIMB_W));
    end
  end

  always_ff @(posedge clk) begin
    pa_r <= pa_nxt;
    pc_r <= pc_nxt;
    p_r  <= p_nxt;
  end

  assign p = p_r;

endmodule

// ===== src/pni_fold.sv =====
module pni_fold #(
  parameter int MAX_FOLDS = pni_pkg::DEF_MAX_FOLDS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pni_pkg::fold_cfg_t  cfg,
  input  pni_pkg::item_t      in_item,
  input  pni_pkg::wide_t      in_m,
  output pni_pkg::item_t      out_item,
  output pni_pkg::wide_t      out_m,
  output pni_pkg::dir_t       out_dir
);

  localparam int STEPS = MAX_FOLDS + 1;
  localparam int CNT_W = $clog2(MAX_FOLDS + 1);

  pni_pkg::item_t   item_r  [STEPS];
  pni_pkg::wide_t   m_r     [STEPS];
  logic [CNT_W-1:0] n_r     [STEPS];
  logic             phase_r [STEPS];
  logic             done_r  [STEPS];
  pni_pkg::dir_t    dir_r   [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    pni_pkg::item_t   cur_item, nxt_item;
    pni_pkg::wide_t   cur_m, nxt_m;
    logic [CNT_W-1:0] cur_n, nxt_n;
    logic             cur_phase, nxt_phase, cur_done, nxt_done;
    pni_pkg::dir_t    cur_dir, nxt_dir;
    logic             down, up;

    if (k == 0) begin : g_first
      assign cur_item  = in_item;
      assign cur_m     = in_m;
      assign cur_n     = '0;
      assign cur_phase = 1'b0;
      assign cur_done  = !cfg.act;
      assign cur_dir   = pni_pkg::DIR_NONE;
    end else begin : g_next
      assign cur_item  = item_r[k-1];
      assign cur_m     = m_r[k-1];
      assign cur_n     = n_r[k-1];
      assign cur_phase = phase_r[k-1];
      assign cur_done  = done_r[k-1];
      assign cur_dir   = dir_r[k-1];
    end

    always_comb begin
      nxt_item  = cur_item;
      nxt_m     = cur_m;
      nxt_n     = cur_n;
      nxt_phase = cur_phase;
      nxt_done  = cur_done;
      nxt_dir   = cur_dir;
      if (cfg.strict) begin
        down = cfg.len < cur_m;
        up   = (cur_m + cfg.len) < 0;
      end else begin
        down = !cur_phase && !(cur_m < cfg.len);
        up   = !((-cfg.len) < cur_m);
      end
      if (!cur_done && (down || up)) begin
        if (cur_n >= CNT_W'(MAX_FOLDS)) begin
          nxt_item.ovf = 1'b1;
          nxt_done     = 1'b1;
        end else if (down) begin
          nxt_item.vx = cur_item.vx - cfg.vec_x;
          nxt_item.vy = cur_item.vy - cfg.vec_y;
          nxt_item.vz = cur_item.vz - cfg.vec_z;
          nxt_m       = cur_m - (cfg.len <<< 1);
          nxt_dir     = pni_pkg::DIR_DOWN;
          nxt_n       = cur_n + CNT_W'(1);
        end else begin
          nxt_item.vx = cur_item.vx + cfg.vec_x;
          nxt_item.vy = cur_item.vy + cfg.vec_y;
          nxt_item.vz = cur_item.vz + cfg.vec_z;
          nxt_m       = cur_m + (cfg.len <<< 1);
          nxt_dir     = pni_pkg::DIR_UP;
          nxt_phase   = 1'b1;
          nxt_n       = cur_n + CNT_W'(1);
        end
      end else begin
        nxt_done = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        item_r[k].valid <= 1'b0;
      end else begin
        item_r[k] <= nxt_item;
      end
      m_r[k]     <= nxt_m;
      n_r[k]     <= nxt_n;
      phase_r[k] <= nxt_phase;
      done_r[k]  <= nxt_done;
      dir_r[k]   <= nxt_dir;
    end
  end

  assign out_item = item_r[STEPS-1];
  assign out_m    = m_r[STEPS-1];
  assign out_dir  = dir_r[STEPS-1];

endmodule

// ===== src/periodic_nearest_image.sv =====
// periodic nearest image
// start with the six point coordinates loads one transaction; busy stays low,
// so a new pair may be started in every clock cycle.
// out_valid marks the folded difference, shift code and overflow flag for
// exactly one cycle; the receiver cannot hold results off.
// throughput is one transaction per cycle.
// the latency is set by three fold chains of MAX_FOLDS+1 steps each (z, sheared
// y, sheared x) and three two-stage multiply units for the sheared coordinates.
// box registers are written through cfg_we, cfg_index, cfg_wdata and must only
// change with no transaction in flight; after a write the derived box products
// settle through bycz_r, then lall_lo_r and lall_hi_r, then lall_r.
// reset clears all valid bits, dropping transactions in flight, and restores
// the vacuum mode with box lengths of 1048576.
module periodic_nearest_image #(
  parameter int COORD_WIDTH = pni_pkg::DEF_COORD_WIDTH,
  parameter int MAX_FOLDS   = pni_pkg::DEF_MAX_FOLDS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       in_first_x,
  input  logic signed [COORD_WIDTH-1:0]       in_first_y,
  input  logic signed [COORD_WIDTH-1:0]       in_first_z,
  input  logic signed [COORD_WIDTH-1:0]       in_second_x,
  input  logic signed [COORD_WIDTH-1:0]       in_second_y,
  input  logic signed [COORD_WIDTH-1:0]       in_second_z,
  input  logic                                cfg_we,
  input  logic [pni_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pni_pkg::CFG_W-1:0]           cfg_wdata,
  output logic                                out_valid,
  output logic signed [COORD_WIDTH-1:0]       out_diff_x,
  output logic signed [COORD_WIDTH-1:0]       out_diff_y,
  output logic signed [COORD_WIDTH-1:0]       out_diff_z,
  output logic signed [pni_pkg::CODE_W-1:0]   out_shift_code,
  output logic                                out_fold_overflow
);

  localparam int WW = pni_pkg::WORK_W;
  localparam int LW = pni_pkg::LEN_W;
  localparam logic signed [WW-1:0] COORD_MAX =
    WW'((65'sd1 <<< (COORD_WIDTH - 1)) - 65'sd1);
  localparam logic signed [WW-1:0] COORD_MIN = -COORD_MAX - 64'sd1;

  // box registers
  logic [1:0]              box_mode_r;
  logic [LW-1:0]           box_a_x_r, box_b_y_r, box_c_z_r;
  logic signed [31:0]      box_b_x_r, box_c_x_r, box_c_y_r;
  logic [2*LW-1:0]         bycz_r, lall_lo_r, lall_hi_r;
  logic [3*LW-1:0]         lall_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_mode_r <= pni_pkg::MODE_VACUUM;
      box_a_x_r  <= pni_pkg::BOX_LEN_RESET;
      box_b_x_r  <= '0;
      box_b_y_r  <= pni_pkg::BOX_LEN_RESET;
      box_c_x_r  <= '0;
      box_c_y_r  <= '0;
      box_c_z_r  <= pni_pkg::BOX_LEN_RESET;
    end else if (cfg_we) begin
      unique case (pni_pkg::reg_idx_t'(cfg_index))
        pni_pkg::REG_BOX_MODE: box_mode_r <= cfg_wdata[1:0];
        pni_pkg::REG_BOX_A_X:  box_a_x_r  <= cfg_wdata[LW-1:0];
        pni_pkg::REG_BOX_B_X:  box_b_x_r  <= $signed(cfg_wdata);
        pni_pkg::REG_BOX_B_Y:  box_b_y_r  <= cfg_wdata[LW-1:0];
        pni_pkg::REG_BOX_C_X:  box_c_x_r  <= $signed(cfg_wdata);
        pni_pkg::REG_BOX_C_Y:  box_c_y_r  <= $signed(cfg_wdata);
        pni_pkg::REG_BOX_C_Z:  box_c_z_r  <= cfg_wdata[LW-1:0];
        default: ;
      endcase
    end
  end

  // scaled box lengths of the sheared axes
  always_ff @(posedge clk) begin
    bycz_r    <= box_b_y_r * box_c_z_r;
    lall_lo_r <= box_a_x_r * bycz_r[LW-1:0];
    lall_hi_r <= box_a_x_r * bycz_r[2*LW-1:LW];
    lall_r    <= (3*LW)'(lall_lo_r) + ((3*LW)'(lall_hi_r) << LW);
  end

  logic is_rect, is_tri;
  assign is_rect = box_mode_r == pni_pkg::MODE_RECT;
  assign is_tri  = box_mode_r == pni_pkg::MODE_TRI;

  logic signed [pni_pkg::MUL_B_W-1:0] mb_cz, mb_by, mb_bx, mb_cx, mb_cy;
  assign mb_cz = $signed({2'b00, box_c_z_r});
  assign mb_by = $signed({2'b00, box_b_y_r});
  assign mb_bx = {box_b_x_r[31], box_b_x_r};
  assign mb_cx = {box_c_x_r[31], box_c_x_r};
  assign mb_cy = {box_c_y_r[31], box_c_y_r};

  assign busy = 1'b0;

  // difference stage
  pni_pkg::item_t d_item_r, d_item_nxt;
  always_comb begin
    d_item_nxt       = '0;
    d_item_nxt.valid = start && !busy;
    d_item_nxt.vx    = pni_pkg::work_t'(in_first_x) - pni_pkg::work_t'(in_second_x);
    d_item_nxt.vy    = pni_pkg::work_t'(in_first_y) - pni_pkg::work_t'(in_second_y);
    d_item_nxt.vz    = pni_pkg::work_t'(in_first_z) - pni_pkg::work_t'(in_second_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_item_r.valid <= 1'b0;
    end else begin
      d_item_r <= d_item_nxt;
    end
  end

  // z fold
  pni_pkg::fold_cfg_t cfg_z, cfg_y, cfg_x;
  pni_pkg::item_t     z_out, z_item, y_out, y_item, x_out, x_item;
  pni_pkg::wide_t     z_m, y_m, x_m;
  pni_pkg::dir_t      z_dir, y_dir, x_dir;

  always_comb begin
    cfg_z.act    = is_rect || is_tri;
    cfg_z.strict = is_rect;
    cfg_z.len    = pni_pkg::wide_t'(box_c_z_r);
    cfg_z.vec_x  = is_tri ? pni_pkg::work_t'(box_c_x_r) : '0;
    cfg_z.vec_y  = is_tri ? pni_pkg::work_t'(box_c_y_r) : '0;
    cfg_z.vec_z  = pni_pkg::work_t'(box_c_z_r);
  end

  pni_fold #(.MAX_FOLDS(MAX_FOLDS)) u_fold_z (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_z),
    .in_item  (d_item_r),
    .in_m     (pni_pkg::widen(d_item_r.vz) <<< 1),
    .out_item (z_out),
    .out_m    (z_m),
    .out_dir  (z_dir)
  );

  always_comb begin
    z_item       = z_out;
    z_item.dir_z = z_dir;
  end

  // sheared y coordinate
  pni_pkg::wide_t ys;
  pni_pkg::item_t zd1_r, zd2_r;

  pni_dmul u_mul_ys (
    .clk (clk),
    .a   (pni_pkg::widen(z_item.vy)),
    .b   (mb_cz),
    .c   (pni_pkg::widen(z_item.vz)),
    .d   (mb_cy),
    .p   (ys)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zd1_r.valid <= 1'b0;
      zd2_r.valid <= 1'b0;
    end else begin
      zd1_r <= z_item;
      zd2_r <= zd1_r;
    end
  end

  // y fold
  always_comb begin
    cfg_y.act    = is_rect || is_tri;
    cfg_y.strict = is_rect;
    cfg_y.len    = is_tri ? pni_pkg::wide_t'(bycz_r) : pni_pkg::wide_t'(box_b_y_r);
    cfg_y.vec_x  = is_tri ? pni_pkg::work_t'(box_b_x_r) : '0;
    cfg_y.vec_y  = pni_pkg::work_t'(box_b_y_r);
    cfg_y.vec_z  = '0;
  end

  pni_fold #(.MAX_FOLDS(MAX_FOLDS)) u_fold_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_y),
    .in_item  (zd2_r),
    .in_m     (is_tri ? (ys <<< 1) : (pni_pkg::widen(zd2_r.vy) <<< 1)),
    .out_item (y_out),
    .out_m    (y_m),
    .out_dir  (y_dir)
  );

  always_comb begin
    y_item       = y_out;
    y_item.dir_y = y_dir;
  end

  // sheared x coordinate
  pni_pkg::wide_t xs, s0;
  pni_pkg::wide_t ysd1_r, ysd2_r;
  pni_pkg::item_t yd1_r, yd2_r, yd3_r, yd4_r;

  pni_dmul u_mul_xs (
    .clk (clk),
    .a   (pni_pkg::widen(y_item.vx)),
    .b   (mb_cz),
    .c   (pni_pkg::widen(y_item.vz)),
    .d   (mb_cx),
    .p   (xs)
  );

  pni_dmul u_mul_s0 (
    .clk (clk),
    .a   (xs),
    .b   (mb_by),
    .c   (ysd2_r),
    .d   (mb_bx),
    .p   (s0)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yd1_r.valid <= 1'b0;
      yd2_r.valid <= 1'b0;
      yd3_r.valid <= 1'b0;
      yd4_r.valid <= 1'b0;
    end else begin
      yd1_r <= y_item;
      yd2_r <= yd1_r;
      yd3_r <= yd2_r;
      yd4_r <= yd3_r;
    end
    ysd1_r <= y_m >>> 1;
    ysd2_r <= ysd1_r;
  end

  // x fold
  always_comb begin
    cfg_x.act    = is_rect || is_tri;
    cfg_x.strict = is_rect;
    cfg_x.len    = is_tri ? pni_pkg::wide_t'(lall_r) : pni_pkg::wide_t'(box_a_x_r);
    cfg_x.vec_x  = pni_pkg::work_t'(box_a_x_r);
    cfg_x.vec_y  = '0;
    cfg_x.vec_z  = '0;
  end

  pni_fold #(.MAX_FOLDS(MAX_FOLDS)) u_fold_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_x),
    .in_item  (yd4_r),
    .in_m     (is_tri ? (s0 <<< 1) : (pni_pkg::widen(yd4_r.vx) <<< 1)),
    .out_item (x_out),
    .out_m    (x_m),
    .out_dir  (x_dir)
  );

  always_comb begin
    x_item       = x_out;
    x_item.dir_x = x_dir;
  end

  // output stage
  logic                               out_valid_r;
  logic signed [COORD_WIDTH-1:0]      diff_x_r, diff_y_r, diff_z_r;
  logic signed [COORD_WIDTH-1:0]      diff_x_nxt, diff_y_nxt, diff_z_nxt;
  logic signed [pni_pkg::CODE_W-1:0]  code_r, code_nxt;
  logic                               ovf_r;

  always_comb begin
    if (x_item.vx > COORD_MAX) begin
      diff_x_nxt = COORD_MAX[COORD_WIDTH-1:0];
    end else if (x_item.vx < COORD_MIN) begin
      diff_x_nxt = COORD_MIN[COORD_WIDTH-1:0];
    end else begin
      diff_x_nxt = x_item.vx[COORD_WIDTH-1:0];
    end
    if (x_item.vy > COORD_MAX) begin
      diff_y_nxt = COORD_MAX[COORD_WIDTH-1:0];
    end else if (x_item.vy < COORD_MIN) begin
      diff_y_nxt = COORD_MIN[COORD_WIDTH-1:0];
    end else begin
      diff_y_nxt = x_item.vy[COORD_WIDTH-1:0];
    end
    if (x_item.vz > COORD_MAX) begin
      diff_z_nxt = COORD_MAX[COORD_WIDTH-1:0];
    end else if (x_item.vz < COORD_MIN) begin
      diff_z_nxt = COORD_MIN[COORD_WIDTH-1:0];
    end else begin
      diff_z_nxt = x_item.vz[COORD_WIDTH-1:0];
    end
    if (is_rect) begin
      code_nxt = pni_pkg::dir_weight(x_item.dir_x, pni_pkg::SHIFT_X)
               + pni_pkg::dir_weight(x_item.dir_y, pni_pkg::SHIFT_Y)
               + pni_pkg::dir_weight(x_item.dir_z, pni_pkg::SHIFT_Z);
    end else begin
      code_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= x_item.valid;
    end
    diff_x_r <= diff_x_nxt;
    diff_y_r <= diff_y_nxt;
    diff_z_r <= diff_z_nxt;
    code_r   <= code_nxt;
    ovf_r    <= x_item.ovf;
  end

  assign out_valid         = out_valid_r;
  assign out_diff_x        = diff_x_r;
  assign out_diff_y        = diff_y_r;
  assign out_diff_z        = diff_z_r;
  assign out_shift_code    = code_r;
  assign out_fold_overflow = ovf_r;

endmodule

// ===== src/pni_checker.sv =====
`include "periodic_nearest_image_assert.svh"

module pni_checker #(
  parameter int MAX_FOLDS = pni_pkg::DEF_MAX_FOLDS
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic signed [pni_pkg::CODE_W-1:0]   out_shift_code
);

  localparam int LAT = pni_pkg::pipe_latency(MAX_FOLDS);

  // every transaction gives one result after the fixed latency
  `PNI_ASSERT_DELAY(a_result_follows, clk, rst_n, start && !busy, LAT, out_valid)

  // no result without a transaction that latency ago
  `PNI_ASSERT_IMPL(a_no_spurious_result, clk, rst_n, out_valid, $past(start && !busy, LAT))

  `PNI_ASSERT_IMPL(a_code_range, clk, rst_n, out_valid, (out_shift_code <= 5'sd13) && (out_shift_code >= -5'sd13))

endmodule

bind periodic_nearest_image pni_checker #(
  .MAX_FOLDS (MAX_FOLDS)
) u_pni_checker (.*);

// ===== tb/periodic_nearest_image_test.sv =====
`default_nettype none

module periodic_nearest_image_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_FOLDS = pni_pkg::DEF_MAX_FOLDS;
  localparam int DRAIN = pni_pkg::pipe_latency(pni_pkg::DEF_MAX_FOLDS) + 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic signed [31:0] fx, fy, fz, sx, sy, sz;
  } pair_t;

  typedef struct {
    logic signed [31:0] dx, dy, dz;
    logic signed [4:0]  code;
    logic               ovf;
  } image_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_first_x = '0, in_first_y = '0, in_first_z = '0;
  logic signed [31:0] in_second_x = '0, in_second_y = '0, in_second_z = '0;
  logic cfg_we = 1'b0;
  logic [pni_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pni_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic out_valid;
  logic signed [31:0] out_diff_x, out_diff_y, out_diff_z;
  logic signed [pni_pkg::CODE_W-1:0] out_shift_code;
  logic out_fold_overflow;

  // local copy of the box registers
  logic [1:0]         box_mode = pni_pkg::MODE_VACUUM;
  logic [30:0]        box_ax = pni_pkg::BOX_LEN_RESET, box_by = pni_pkg::BOX_LEN_RESET;
  logic [30:0]        box_cz = pni_pkg::BOX_LEN_RESET;
  logic signed [31:0] box_bx = '0, box_cx = '0, box_cy = '0;

  pair_t  pending_pairs[$];
  image_t expected_images[$];
  int     errors = 0;
  int     cycles = 0;
  int     idle_pct = 11;

  periodic_nearest_image dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_first_x(in_first_x), .in_first_y(in_first_y), .in_first_z(in_first_z),
    .in_second_x(in_second_x), .in_second_y(in_second_y), .in_second_z(in_second_z),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_diff_x(out_diff_x), .out_diff_y(out_diff_y),
    .out_diff_z(out_diff_z), .out_shift_code(out_shift_code),
    .out_fold_overflow(out_fold_overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [127:0] widen128(input logic signed [63:0] v);
    widen128 = v;
  endfunction

  function automatic logic signed [63:0] rect_fold(input logic signed [63:0] d_in,
      input logic [30:0] len31, input logic signed [4:0] w,
      inout logic signed [4:0] sh, inout logic ovf);
    logic signed [63:0]  d, len;
    logic signed [127:0] t, l;
    int n, dir;
    bit done;
    d = d_in;
    len = {33'b0, len31};
    l = widen128(len);
    n = 0;
    done = 0;
    while (!done) begin
      t = widen128(d) + widen128(d);
      if (l < t) dir = -1;
      else if (t + l < 0) dir = 1;
      else dir = 0;
      if (dir == 0) done = 1;
      else if (n >= N_FOLDS) begin
        ovf = 1'b1;
        done = 1;
      end else begin
        if (dir < 0) begin
          d = d - len;
          sh = -w;
        end else begin
          d = d + len;
          sh = w;
        end
        n++;
      end
    end
    rect_fold = d;
  endfunction

  function automatic void sheared_measure(input int axis, input logic signed [63:0] x,
      input logic signed [63:0] y, input logic signed [63:0] z,
      output logic signed [127:0] s2, output logic signed [127:0] len);
    logic signed [127:0] ax, by, cz, bx, cx, cy, s, ys, xs;
    ax = {97'b0, box_ax};
    by = {97'b0, box_by};
    cz = {97'b0, box_cz};
    bx = box_bx;
    cx = box_cx;
    cy = box_cy;
    ys = widen128(y) * cz - cy * widen128(z);
    if (axis == 2) begin
      s = widen128(z);
      len = cz;
    end else if (axis == 1) begin
      s = ys;
      len = by * cz;
    end else begin
      xs = widen128(x) * cz - cx * widen128(z);
      s = by * xs - bx * ys;
      len = ax * (by * cz);
    end
    s2 = s + s;
  endfunction

  function automatic void sheared_fold(input int axis, inout logic signed [63:0] x,
      inout logic signed [63:0] y, inout logic signed [63:0] z, inout logic ovf);
    logic signed [63:0]  vx, vy, vz;
    logic signed [127:0] s2, len;
    int n;
    bit go;
    n = 0;
    if (axis == 2) begin
      vx = box_cx; vy = box_cy; vz = {33'b0, box_cz};
    end else if (axis == 1) begin
      vx = box_bx; vy = {33'b0, box_by}; vz = '0;
    end else begin
      vx = {33'b0, box_ax}; vy = '0; vz = '0;
    end
    for (int dir = 0; dir < 2; dir++) begin
      go = 1;
      while (go) begin
        sheared_measure(axis, x, y, z, s2, len);
        go = (dir == 0) ? !(s2 < len) : !(-len < s2);
        if (go) begin
          if (n >= N_FOLDS) begin
            ovf = 1'b1;
            return;
          end
          if (dir == 0) begin
            x = x - vx; y = y - vy; z = z - vz;
          end else begin
            x = x + vx; y = y + vy; z = z + vz;
          end
          n++;
        end
      end
    end
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) clamp32 = 32'sh7fffffff;
    else if (v < -64'sd2147483648) clamp32 = 32'sh80000000;
    else clamp32 = v[31:0];
  endfunction

  function automatic image_t predict_image(input pair_t p);
    image_t r;
    logic signed [63:0] x, y, z;
    logic signed [4:0]  sa, sb, sc;
    logic ovf;
    x = 64'(p.fx) - 64'(p.sx);
    y = 64'(p.fy) - 64'(p.sy);
    z = 64'(p.fz) - 64'(p.sz);
    sa = '0; sb = '0; sc = '0; ovf = 1'b0;
    if (box_mode == pni_pkg::MODE_RECT) begin
      x = rect_fold(x, box_ax, pni_pkg::SHIFT_X, sa, ovf);
      y = rect_fold(y, box_by, pni_pkg::SHIFT_Y, sb, ovf);
      z = rect_fold(z, box_cz, pni_pkg::SHIFT_Z, sc, ovf);
    end else if (box_mode == pni_pkg::MODE_TRI) begin
      sheared_fold(2, x, y, z, ovf);
      sheared_fold(1, x, y, z, ovf);
      sheared_fold(0, x, y, z, ovf);
    end
    r.dx = clamp32(x);
    r.dy = clamp32(y);
    r.dz = clamp32(z);
    r.code = sa + sb + sc;
    r.ovf = ovf;
    predict_image = r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  // driver
  always @(posedge clk) begin : drive
    pair_t p;
    if (!rst_n) start <= 1'b0;
    else if (!start || !busy) begin
      if (pending_pairs.size() != 0 && $urandom_range(99) >= idle_pct) begin
        p = pending_pairs.pop_front();
        start <= 1'b1;
        in_first_x <= p.fx; in_first_y <= p.fy; in_first_z <= p.fz;
        in_second_x <= p.sx; in_second_y <= p.sy; in_second_z <= p.sz;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    pair_t p;
    image_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[periodic_nearest_image] ERROR");
      $finish;
    end else begin
      if (rst_n && start && !busy) begin
        p.fx = in_first_x; p.fy = in_first_y; p.fz = in_first_z;
        p.sx = in_second_x; p.sy = in_second_y; p.sz = in_second_z;
        expected_images.push_back(predict_image(p));
      end
      if (rst_n && out_valid) begin
        if (expected_images.size() == 0) begin
          errors++;
          $display("%0t unexpected transaction: expected none actual %0h %0h %0h", $time,
                   out_diff_x, out_diff_y, out_diff_z);
        end else begin
          e = expected_images.pop_front();
          check_field("diff_x", e.dx, out_diff_x);
          check_field("diff_y", e.dy, out_diff_y);
          check_field("diff_z", e.dz, out_diff_z);
          check_field("shift_code", 32'(e.code), 32'(out_shift_code));
          check_field("fold_overflow", 32'(e.ovf), 32'(out_fold_overflow));
        end
      end
    end
  end

  task automatic write_reg(input pni_pkg::reg_idx_t idx, input logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      pni_pkg::REG_BOX_MODE: box_mode = v[1:0];
      pni_pkg::REG_BOX_A_X:  box_ax = v[30:0];
      pni_pkg::REG_BOX_B_X:  box_bx = v;
      pni_pkg::REG_BOX_B_Y:  box_by = v[30:0];
      pni_pkg::REG_BOX_C_X:  box_cx = v;
      pni_pkg::REG_BOX_C_Y:  box_cy = v;
      pni_pkg::REG_BOX_C_Z:  box_cz = v[30:0];
      default: ;
    endcase
  endtask

  task automatic set_box(input logic [31:0] mode, input logic [31:0] ax,
      input logic [31:0] bx, input logic [31:0] by, input logic [31:0] cx,
      input logic [31:0] cy, input logic [31:0] cz);
    write_reg(pni_pkg::REG_BOX_MODE, mode);
    write_reg(pni_pkg::REG_BOX_A_X, ax);
    write_reg(pni_pkg::REG_BOX_B_X, bx);
    write_reg(pni_pkg::REG_BOX_B_Y, by);
    write_reg(pni_pkg::REG_BOX_C_X, cx);
    write_reg(pni_pkg::REG_BOX_C_Y, cy);
    write_reg(pni_pkg::REG_BOX_C_Z, cz);
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (6) @(posedge clk);
  endtask

  task automatic add_pair(input logic [31:0] fx, input logic [31:0] fy,
      input logic [31:0] fz, input logic [31:0] sx, input logic [31:0] sy,
      input logic [31:0] sz);
    pair_t p;
    p.fx = fx; p.fy = fy; p.fz = fz;
    p.sx = sx; p.sy = sy; p.sz = sz;
    pending_pairs.push_back(p);
  endtask

  // mostly moderate points with a spread of separations, some fully random
  task automatic add_random(input int count);
    logic signed [31:0] s[3], f[3];
    for (int i = 0; i < count; i++) begin
      for (int k = 0; k < 3; k++) begin
        if ($urandom_range(9) == 0) begin
          s[k] = $urandom;
          f[k] = $urandom;
        end else begin
          s[k] = $signed($urandom) >>> $urandom_range(2, 12);
          f[k] = s[k] + ($signed($urandom) >>> $urandom_range(1, 31));
        end
      end
      add_pair(f[0], f[1], f[2], s[0], s[1], s[2]);
    end
  endtask

  task automatic drain_all();
    while (pending_pairs.size() != 0 || start || expected_images.size() != 0)
      @(negedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // vacuum after reset: saturation extremes
    idle_pct = 11;
    add_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
             32'h80000000);
    add_pair(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
             32'h7fffffff);
    add_pair(0, 0, 0, 0, 0, 0);
    add_pair(32'hffffffff, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h7fffffff,
             32'h80000000);
    add_random(100);
    drain_all();

    // rectangular box: strict half-length boundaries and fold limit
    set_box(pni_pkg::MODE_RECT, 32'd1048576, 32'd5, 32'd2097152, 32'd7, 32'd9,
            32'd3145728);
    add_pair(32'd524288, 32'd1048576, 32'd1572864, 0, 0, 0);
    add_pair(32'd524289, 32'd1048577, 32'd1572865, 0, 0, 0);
    add_pair(0, 0, 0, 32'd524288, 32'd1048576, 32'd1572864);
    add_pair(0, 0, 0, 32'd524289, 32'd1048577, 32'd1572865);
    add_pair(32'd10485760, 32'd0, 32'd31457280, 0, 32'd20971520, 0);
    add_pair(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
             32'h80000000);
    add_random(200);
    drain_all();

    // rectangular with degenerate lengths
    idle_pct = 57;
    set_box(pni_pkg::MODE_RECT, 32'd1, 32'hffffffff, 32'd0, 32'h80000000, 32'h7fffffff,
            32'h7fffffff);
    add_pair(32'd1, 32'd1, 32'h40000000, 0, 32'd0, 32'hc0000000);
    add_random(100);
    drain_all();

    // sheared box
    set_box(pni_pkg::MODE_TRI, 32'd4194304, 32'd1048576, 32'd3145728, 32'hfff00000,
            32'd1572864, 32'd5242880);
    add_pair(0, 0, 32'd2621440, 0, 0, 0);
    add_pair(0, 0, 0, 0, 0, 32'd2621440);
    add_pair(0, 32'd1572864, 0, 0, 0, 0);
    add_pair(32'd2097152, 0, 0, 0, 0, 0);
    add_pair(0, 0, 0, 32'd2097152, 0, 0);
    add_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
             32'h80000000);
    add_random(250);
    drain_all();

    // sheared box at the register extremes
    idle_pct = 0;
    set_box(pni_pkg::MODE_TRI, 32'hffffffff, 32'h80000000, 32'd0, 32'h7fffffff,
            32'h80000000, 32'd1);
    add_pair(32'd3, 0, 32'd1, 0, 0, 0);
    add_random(150);
    drain_all();

    // unused mode code behaves as vacuum
    set_box(MODE_UNUSED, 32'd123456, 32'h12345678, 32'd654321, 32'h0f0f0f0f, 32'hf0f0f0f0,
            32'd777);
    add_random(100);
    drain_all();

    // rectangular with the largest lengths
    set_box(pni_pkg::MODE_RECT, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
            32'h7fffffff, 32'h7fffffff);
    add_pair(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
             32'h80000000);
    add_random(100);
    drain_all();

    if (errors == 0 && expected_images.size() == 0) begin
      $display("[periodic_nearest_image] OK");
    end else begin
      $display("[periodic_nearest_image] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/pni_pkg.sv
src/pni_dmul.sv
src/pni_fold.sv
src/periodic_nearest_image.sv
src/pni_checker.sv
tb/periodic_nearest_image_test.sv
